### rtl/core/dles_pkg.sv
// Shared types and constants for the delta-list event scheduler.
`default_nettype none
package dles_pkg;

  localparam int unsigned KindW = 4;
  localparam int unsigned ArgW  = 32;
  localparam int unsigned SlotW = 4;
  localparam int unsigned CycW  = 32;
  localparam int unsigned MaxRes = 16;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdStep   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StAdded   = 3'd0,
    StFull    = 3'd1,
    StRemoved = 3'd2,
    StAbsent  = 3'd3,
    StFired   = 3'd4,
    StNoEvent = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KindW-1:0] event_kind;
    logic [ArgW-1:0]  event_arg;
    logic [31:0]      delay;
    logic [SlotW-1:0] slot;
    logic [CycW-1:0]  cycles;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] out_slot;
    logic [KindW-1:0] out_kind;
    logic [ArgW-1:0]  out_arg;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    SIdle,
    SAddHead,
    SAddWalk,
    SAddLink,
    SRemFold,
    SRemWalk,
    SStepHead,
    SStepFire,
    SEmit,
    SWait
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic   load;
    state_e op;
    logic   emit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    cmd_e   cmd;
    logic   full;
    logic   used_rm;
    logic   head_nil;
    logic   rem_is_head;
    logic   walk_done;
    logic   step_stop;
    logic   step_fire;
    logic   step_end;
    logic   out_busy;
    logic   out_taken;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/core/dles_ctrl.sv
// Sequencing state machine for the scheduler.
`default_nettype none
module dles_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dles_pkg::dp_sts_t sts_i,
  output dles_pkg::dp_cmd_t cmd_o
);
  import dles_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SEmit;
          unique case (sts_i.cmd)
            CmdAdd:    if (!sts_i.full) state_d = SAddHead;
            CmdRemove: if (sts_i.used_rm) state_d = SRemFold;
            CmdStep:   state_d = SStepHead;
            default:   state_d = SEmit;
          endcase
        end
      end
      SAddHead: state_d = sts_i.head_nil ? SEmit : SAddWalk;
      SAddWalk: if (sts_i.walk_done) state_d = SAddLink;
      SAddLink: state_d = SEmit;
      SRemFold: state_d = sts_i.rem_is_head ? SEmit : SRemWalk;
      SRemWalk: if (sts_i.walk_done) state_d = SEmit;
      SStepHead: begin
        if (sts_i.step_end) begin
          state_d = SEmit;
        end else if (sts_i.step_fire) begin
          state_d = SStepFire;
        end
      end
      SStepFire: begin
        if (!sts_i.out_busy) begin
          state_d = sts_i.step_stop ? SWait : SStepHead;
        end
      end
      SEmit: if (!sts_i.out_busy) state_d = SWait;
      SWait: if (sts_i.out_taken || !sts_i.out_busy) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == SIdle);
    cmd_o.load  = (state_q == SIdle) && in_valid_i;
    cmd_o.op    = state_q;
    cmd_o.emit  = ((state_q == SEmit) || (state_q == SStepFire)) && !sts_i.out_busy;
  end

endmodule
`default_nettype wire

### rtl/core/dles_dp.sv
// Slot pool, linked delta list and result register.
`default_nettype none
module dles_dp #(
  parameter int unsigned NumSlots  = 16,
  parameter int unsigned DelayBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dles_pkg::in_item_t  in_data_i,
  input  dles_pkg::dp_cmd_t   cmd_i,
  output dles_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dles_pkg::out_item_t out_data_o
);
  import dles_pkg::*;

  localparam int unsigned IdxW = $clog2(NumSlots + 1);
  localparam int unsigned PW   = $clog2(NumSlots);
  localparam logic [IdxW-1:0] Nil = IdxW'(NumSlots);
  localparam int unsigned CntW = $clog2(MaxRes + 1);

  logic [NumSlots-1:0]  used_q, used_d;
  logic [IdxW-1:0]      next_q  [NumSlots];
  logic [DelayBits-1:0] delta_q [NumSlots];
  logic [KindW-1:0]     kind_q  [NumSlots];
  logic [ArgW-1:0]      arg_q   [NumSlots];
  logic [IdxW-1:0]      head_q, head_d;

  in_item_t             it_q;
  logic [PW-1:0]        new_q;
  logic                 full_q, rm_hit_q;
  logic [DelayBits-1:0] d_q, d_d;
  logic [IdxW-1:0]      q_q, q_d, p_q, p_d;
  logic [CntW-1:0]      k_q, k_d;
  logic [CycW-1:0]      cyc_q, cyc_d;

  logic                 ov_q;
  out_item_t            od_q, od_d;
  logic                 fire_last;

  logic [PW-1:0]        free_idx;
  logic                 full;
  logic [PW-1:0]        rm;
  logic [PW-1:0]        hp, pp, qp, np;
  logic                 p_nil, n_nil, n_hold, cap;
  logic [DelayBits-1:0] dly, hsub, cyc_ext;
  logic [DelayBits-1:0] hd_new;
  logic                 walk_go;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = PW'(i);
        full     = 1'b0;
      end
    end
  end

  assign rm    = PW'(it_q.slot);
  assign hp    = head_q[PW-1:0];
  assign pp    = p_q[PW-1:0];
  assign qp    = q_q[PW-1:0];
  assign np    = next_q[hp][PW-1:0];
  assign p_nil = (p_q >= Nil);
  assign n_nil = (next_q[hp] >= Nil);
  assign dly   = DelayBits'(it_q.delay);
  assign cyc_ext = (DelayBits >= CycW) ? DelayBits'(cyc_q) :
                   ((cyc_q >> DelayBits) != '0 ? '1 : DelayBits'(cyc_q));
  assign hsub  = (cyc_ext < delta_q[hp]) ? cyc_ext : delta_q[hp];
  assign hd_new = delta_q[hp] - hsub;
  assign n_hold = (delta_q[np] > cyc_ext);
  assign cap    = (k_q + 1'b1 >= CntW'(MaxRes));
  assign walk_go = !p_nil && (d_q > delta_q[pp]);

  always_comb begin
    sts_o.cmd         = cmd_e'(in_data_i.cmd);
    sts_o.full        = full;
    sts_o.used_rm     = ((in_data_i.slot) < SlotW'(NumSlots) || NumSlots > 15)
                        && used_q[PW'(in_data_i.slot)];
    sts_o.head_nil    = (head_q >= Nil);
    sts_o.rem_is_head = (head_q == IdxW'(rm));
    sts_o.walk_done   = (cmd_i.op == SAddWalk) ? !walk_go :
                        (p_nil || next_q[pp] == IdxW'(rm));
    sts_o.step_end    = (head_q >= Nil) || (k_q >= CntW'(MaxRes)) ||
                        (cyc_q == '0 && delta_q[hp] != '0);
    sts_o.step_fire   = (hd_new == '0);
    sts_o.step_stop   = cap || n_nil || n_hold;
    sts_o.out_busy    = ov_q && !out_ready_i;
    sts_o.out_taken   = ov_q && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= Nil;
      ov_q   <= 1'b0;
      k_q    <= '0;
    end else begin
      used_q <= used_d;
      head_q <= head_d;
      k_q    <= k_d;
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    q_q   <= q_d;
    p_q   <= p_d;
    cyc_q <= cyc_d;
    if (cmd_i.emit) od_q <= od_d;
    if (cmd_i.load) begin
      it_q     <= in_data_i;
      new_q    <= free_idx;
      full_q   <= full;
      rm_hit_q <= sts_o.used_rm;
    end
    unique case (cmd_i.op)
      SAddHead: begin
        kind_q[new_q] <= it_q.event_kind;
        arg_q[new_q]  <= it_q.event_arg;
        if (head_q >= Nil) begin
          delta_q[new_q] <= dly;
          next_q[new_q]  <= Nil;
        end else if (dly < delta_q[hp]) begin
          delta_q[hp]    <= delta_q[hp] - dly;
          delta_q[new_q] <= dly;
          next_q[new_q]  <= head_q;
        end
      end
      SAddLink: begin
        if (!(q_q == Nil)) begin
          next_q[qp]     <= IdxW'(new_q);
          next_q[new_q]  <= p_nil ? Nil : p_q;
          delta_q[new_q] <= d_q;
          if (!p_nil) delta_q[pp] <= delta_q[pp] - d_q;
        end
      end
      SRemFold: begin
        if (next_q[rm] < Nil) begin
          delta_q[next_q[rm][PW-1:0]] <= delta_q[next_q[rm][PW-1:0]] + delta_q[rm];
        end
      end
      SRemWalk: begin
        if (!p_nil && next_q[pp] == IdxW'(rm)) next_q[pp] <= next_q[rm];
      end
      SStepHead: begin
        if (!sts_o.step_end) delta_q[hp] <= hd_new;
      end
      SStepFire: begin
        if (!sts_o.out_busy && !cap && !n_nil && n_hold) begin
          delta_q[np] <= delta_q[np] - cyc_ext;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    used_d = used_q;
    head_d = head_q;
    d_d    = d_q;
    q_d    = q_q;
    p_d    = p_q;
    k_d    = k_q;
    cyc_d  = cyc_q;
    od_d   = '0;
    fire_last = sts_o.step_stop;
    if (cmd_i.load) begin
      k_d   = '0;
      cyc_d = in_data_i.cycles;
    end
    unique case (cmd_i.op)
      SAddHead: begin
        used_d[new_q] = 1'b1;
        q_d = Nil;
        if (head_q >= Nil || dly < delta_q[hp]) begin
          head_d = IdxW'(new_q);
          p_d    = Nil;
        end else begin
          d_d = dly - delta_q[hp];
          q_d = head_q;
          p_d = next_q[hp];
        end
      end
      SAddWalk: begin
        if (walk_go) begin
          d_d = d_q - delta_q[pp];
          q_d = p_q;
          p_d = next_q[pp];
        end
      end
      SRemFold: begin
        used_d[rm] = 1'b0;
        if (head_q == IdxW'(rm)) head_d = next_q[rm];
        p_d = head_q;
      end
      SRemWalk: begin
        if (!(p_nil || next_q[pp] == IdxW'(rm))) p_d = next_q[pp];
      end
      SStepHead: begin
        if (!sts_o.step_end) begin
          cyc_d = cyc_q - CycW'(hsub);
          q_d   = head_q;
        end
      end
      SStepFire: begin
        if (!sts_o.out_busy) begin
          used_d[hp] = 1'b0;
          head_d     = next_q[hp];
          k_d        = k_q + 1'b1;
        end
      end
      default: ;
    endcase
    unique case (cmd_i.op)
      SStepFire: begin
        od_d.status   = StFired;
        od_d.out_slot = SlotW'(hp);
        od_d.out_kind = kind_q[hp];
        od_d.out_arg  = arg_q[hp];
        od_d.last     = fire_last;
      end
      SEmit: begin
        od_d.last = 1'b1;
        unique case (cmd_e'(it_q.cmd))
          CmdAdd: begin
            if (full_q) begin
              od_d.status = StFull;
            end else begin
              od_d.status   = StAdded;
              od_d.out_slot = SlotW'(new_q);
            end
          end
          CmdRemove: begin
            od_d.status   = rm_hit_q ? StRemoved : StAbsent;
            od_d.out_slot = it_q.slot;
          end
          default: od_d.status = StNoEvent;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule
`default_nettype wire

### rtl/core/delta_list_event_scheduler.sv
// Top level of the delta-list event scheduler.
// Commands arrive on the in channel (valid/ready): add, remove or advance time.
// Results leave on the out channel (valid/ready), one per transfer; last marks
// the final result of a command. One command is in flight at a time.
// Add: a first entry goes in from the head check; any other add walks the list
// past the entries whose deltas its delay exceeds, then links in.
// Remove: the head is dropped at the fold step; any other slot is unlinked
// from its predecessor after a walk from the head.
// Advance time: one result per fired event, up to sixteen events; a step that
// fires nothing answers with one no-event result.
// The next command is taken in the cycle after the last result's transfer.
// The result register holds one result; a stalled receiver holds the
// sequencer at the waiting result.
// Reset empties the list and drops any pending result.
// Slot storage is flip-flops; the list walk sets the rate.
`default_nettype none
module delta_list_event_scheduler #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned DELAY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dles_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dles_pkg::out_item_t out_data_o
);
  import dles_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dles_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  dles_dp #(.NumSlots(NUM_SLOTS), .DelayBits(DELAY_BITS)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the delta-list event scheduler, directed table then random traffic.
module testbench;
  import dles_pkg::*;

  localparam int unsigned Pool  = 16;
  localparam logic [4:0]  Nil   = 5'd16;
  localparam int unsigned Limit = 2000000;

  typedef struct {
    in_item_t  it;
    bit        fixed;
    out_item_t want;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  delta_list_event_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  bit          ev_used [Pool];
  logic [4:0]  ev_next [Pool];
  logic [31:0] ev_delta [Pool];
  logic [3:0]  ev_kind [Pool];
  logic [31:0] ev_arg [Pool];
  logic [4:0]  ev_head = Nil;

  out_item_t   pending_q [$];
  row_t        rows [$];
  int          errs = 0;
  int unsigned cyc_cnt = 0;
  bit          long_hold = 1'b0;

  function automatic out_item_t res(status_e st, logic [3:0] sl, logic [3:0] kd,
                                    logic [31:0] ag, logic lst);
    out_item_t o;
    o.status = st; o.out_slot = sl; o.out_kind = kd; o.out_arg = ag; o.last = lst;
    return o;
  endfunction

  function automatic in_item_t mk(cmd_e c, logic [3:0] kd, logic [31:0] ag,
                                  logic [31:0] dl, logic [3:0] sl, logic [31:0] cy);
    in_item_t i;
    i.cmd = c; i.event_kind = kd; i.event_arg = ag; i.delay = dl; i.slot = sl; i.cycles = cy;
    return i;
  endfunction

  task automatic schedule(input in_item_t it, ref out_item_t q [$]);
    int s;
    int n;
    logic [4:0] p;
    logic [4:0] pq;
    logic [4:0] nx;
    logic [31:0] d;
    logic [31:0] cy;
    logic [31:0] sub;
    out_item_t fired [$];
    case (cmd_e'(it.cmd))
      CmdAdd: begin
        s = 0;
        while (s < Pool && ev_used[s]) s++;
        if (s >= Pool) begin
          q.push_back(res(StFull, 0, 0, 0, 1));
        end else begin
          d = it.delay;
          ev_used[s] = 1; ev_kind[s] = it.event_kind; ev_arg[s] = it.event_arg;
          ev_next[s] = Nil;
          if (ev_head == Nil) begin
            ev_delta[s] = d; ev_head = 5'(s);
          end else if (d < ev_delta[ev_head]) begin
            ev_delta[ev_head] -= d; ev_delta[s] = d; ev_next[s] = ev_head; ev_head = 5'(s);
          end else begin
            d -= ev_delta[ev_head];
            pq = ev_head; p = ev_next[pq]; n = 0;
            while (n < Pool && p != Nil && d > ev_delta[p]) begin
              d -= ev_delta[p]; pq = p; p = ev_next[p]; n++;
            end
            ev_next[pq] = 5'(s); ev_next[s] = p; ev_delta[s] = d;
            if (p != Nil) ev_delta[p] -= d;
          end
          q.push_back(res(StAdded, 4'(s), 0, 0, 1));
        end
      end
      CmdRemove: begin
        s = it.slot;
        if (!ev_used[s]) begin
          q.push_back(res(StAbsent, it.slot, 0, 0, 1));
        end else begin
          ev_used[s] = 0; nx = ev_next[s];
          if (nx != Nil) ev_delta[nx] += ev_delta[s];
          if (ev_head == 5'(s)) begin
            ev_head = nx;
          end else begin
            p = ev_head;
            while (p != Nil && ev_next[p] != 5'(s)) p = ev_next[p];
            if (p != Nil) ev_next[p] = nx;
          end
          q.push_back(res(StRemoved, it.slot, 0, 0, 1));
        end
      end
      CmdStep: begin
        cy = it.cycles;
        while (ev_head != Nil && fired.size() < MaxRes) begin
          p = ev_head;
          if (cy == 0 && ev_delta[p] != 0) break;
          sub = (cy < ev_delta[p]) ? cy : ev_delta[p];
          ev_delta[p] -= sub; cy -= sub;
          if (ev_delta[p] == 0) begin
            ev_used[p] = 0; ev_head = ev_next[p];
            fired.push_back(res(StFired, p[3:0], ev_kind[p], ev_arg[p], 0));
          end
        end
        if (fired.size() == 0) begin
          q.push_back(res(StNoEvent, 0, 0, 0, 1));
        end else begin
          fired[fired.size()-1].last = 1;
          foreach (fired[i]) q.push_back(fired[i]);
        end
      end
      default: q.push_back(res(StNoEvent, 0, 0, 0, 1));
    endcase
  endtask

  // Row fixed flags and wanted results ride along with each accepted command in order.
  bit fixed_flags [$];
  out_item_t fixed_wants [$];

  always @(posedge clk_i) begin
    out_item_t e;
    out_item_t scratch [$];
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errs++;
      end else begin
        e = pending_q.pop_front();
        if (e !== out_data_o) begin
          $display("%0t: expected %h, got %h", $time, e, out_data_o);
          errs++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      if (fixed_flags.pop_front()) begin
        schedule(in_data_i, scratch);
        pending_q.push_back(fixed_wants.pop_front());
      end else begin
        void'(fixed_wants.pop_front());
        schedule(in_data_i, pending_q);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom % 100;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic send(input in_item_t it, input bit fx, input out_item_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    fixed_flags.push_back(fx);
    fixed_wants.push_back(w);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic in_item_t rand_item();
    int r;
    logic [31:0] dl;
    logic [31:0] cy;
    r = $urandom % 100;
    case ($urandom % 10)
      0: dl = $urandom;
      1: dl = 32'hFFFF_FFFF;
      2: dl = 0;
      default: dl = $urandom_range(0, 40);
    endcase
    case ($urandom % 10)
      0: cy = $urandom;
      1: cy = 32'hFFFF_FFFF;
      2: cy = 0;
      default: cy = $urandom_range(0, 25);
    endcase
    if (r < 45) return mk(CmdAdd, 4'($urandom), $urandom, dl, 4'($urandom), cy);
    if (r < 68) return mk(CmdRemove, 4'($urandom), $urandom, dl, 4'($urandom), cy);
    if (r < 95) return mk(CmdStep, 4'($urandom), $urandom, dl, 4'($urandom), cy);
    return mk(CmdNone, 4'($urandom), $urandom, dl, 4'($urandom), cy);
  endfunction

  always begin
    int g;
    @(posedge clk_i);
    if (long_hold) begin
      out_ready_i <= 1'b0;
      repeat (400) @(posedge clk_i);
      long_hold = 1'b0;
    end
    g = pick_gap();
    if (g > 0) begin
      out_ready_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
    repeat ($urandom_range(1, 20)) @(posedge clk_i);
  end

  initial begin
    row_t rw;
    foreach (ev_used[i]) begin
      ev_used[i] = 0; ev_next[i] = 0; ev_delta[i] = 0; ev_kind[i] = 0; ev_arg[i] = 0;
    end
    rw.fixed = 1;
    rw.it = mk(CmdStep, 0, 0, 0, 0, 0);              rw.want = res(StNoEvent, 0, 0, 0, 1);
    rows.push_back(rw);
    rw.it = mk(CmdRemove, 0, 0, 0, 15, 0);           rw.want = res(StAbsent, 15, 0, 0, 1);
    rows.push_back(rw);
    rw.it = mk(CmdNone, 4'hF, '1, '1, 4'hF, '1);     rw.want = res(StNoEvent, 0, 0, 0, 1);
    rows.push_back(rw);
    rw.it = mk(CmdAdd, 4'hF, '1, '1, 0, 0);          rw.want = res(StAdded, 0, 0, 0, 1);
    rows.push_back(rw);
    rw.it = mk(CmdAdd, 0, 0, 0, 0, 0);               rw.want = res(StAdded, 1, 0, 0, 1);
    rows.push_back(rw);
    rw.fixed = 0;
    rw.it = mk(CmdAdd, 4'h3, 32'h1234_5678, 5, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdAdd, 4'h4, 32'h8765_4321, 5, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdAdd, 4'h5, 32'hA5A5_5A5A, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdStep, 0, 0, 0, 0, 0);               rows.push_back(rw);
    rw.it = mk(CmdRemove, 0, 0, 0, 2, 0);             rows.push_back(rw);
    rw.fixed = 1;
    rw.it = mk(CmdRemove, 0, 0, 0, 2, 0);            rw.want = res(StAbsent, 2, 0, 0, 1);
    rows.push_back(rw);
    rw.fixed = 0;
    rw.it = mk(CmdStep, 0, 0, 0, 0, '1);              rows.push_back(rw);
    rw.fixed = 1;
    rw.it = mk(CmdStep, 0, 0, 0, 0, 3);              rw.want = res(StNoEvent, 0, 0, 0, 1);
    rows.push_back(rw);
    rw.fixed = 0;
    for (int i = 0; i < Pool; i++) begin
      rw.it = mk(CmdAdd, 4'(i), $urandom, 32'(i % 3 == 0 ? 0 : i), 0, 0);
      rows.push_back(rw);
    end
    rw.fixed = 1;
    rw.it = mk(CmdAdd, 0, 0, 1, 0, 0);               rw.want = res(StFull, 0, 0, 0, 1);
    rows.push_back(rw);
    rw.fixed = 0;
    rw.it = mk(CmdStep, 0, 0, 0, 0, '1);              rows.push_back(rw);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send(rows[i].it, rows[i].fixed, rows[i].want);
    for (int i = 0; i < 240; i++) begin
      if (i == 100) long_hold = 1'b1;
      if (i == 200) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send(rand_item(), 0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
